// ----- hw/rtl/uamhd_pkg.sv -----
package uamhd_pkg;

  // Node id encoding bytes
  localparam logic [7:0] NODE_NULL     = 8'h00;
  localparam logic [7:0] NODE_BYTE_NS  = 8'h01;
  localparam logic [7:0] NODE_WORD_NS  = 8'h02;
  // Body encoding byte for a binary body
  localparam logic [7:0] BODY_BINARY   = 8'h01;

  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BAD_NODE = 3'd2,
    ST_BAD_BODY = 3'd3,
    ST_NEG_LEN  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  typedef enum logic [6:0] {
    PH_NODE  = 7'b0000001,
    PH_NS    = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_BODY  = 7'b0001000,
    PH_LEN   = 7'b0010000,
    PH_PAY   = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [31:0] type_id;
    logic [15:0] type_ns;
    logic [30:0] payload_length;
  } out_beat_t;

endpackage

// ----- hw/rtl/ua_message_header_deframer_top.sv -----
// Channel  | Ports                        | Beat
// ---------+------------------------------+---------------------------------
// input    | in_valid, in_stall, in_data  | one buffer byte and its end flag
// result   | out_valid, out_stall, out_data | status, payload byte, header
//
// One byte per cycle sustained while out_stall is low; a byte passes the input
// register, then the result register, before its result is valid.
// The per-byte parse is a single pass through the header state machine.
// Reset is synchronous on rst_n and returns the parser to expect a node
// encoding byte with both registers empty.
// While out_stall holds a result, one further byte is taken into the input
// register; in_stall rises only once that register is also full.
module ua_message_header_deframer_top import uamhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      beat_vld;
  in_beat_t  beat;
  logic      adv;
  logic      res_vld;
  out_beat_t res;

  // Stall input only when the held byte cannot move on
  assign in_stall = beat_vld && !adv;

  uamhd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .beat_vld (beat_vld),
    .beat     (beat)
  );

  uamhd_parse_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_vld (beat_vld),
    .beat     (beat),
    .adv      (adv),
    .res_vld  (res_vld),
    .res      (res)
  );

  uamhd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_vld  (beat_vld),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/uamhd_in_stage.sv -----
module uamhd_in_stage import uamhd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_beat_t in_data,
  input  logic     adv,
  output logic     beat_vld,
  output in_beat_t beat
);

  logic     beat_vld_r;
  logic     beat_vld_nxt;
  in_beat_t beat_r;
  logic     load;

  assign load = in_valid && !in_stall;

  // Hold the beat until the parser takes it
  always_comb begin
    beat_vld_nxt = beat_vld_r;
    if (load) begin
      beat_vld_nxt = 1'b1;
    end else if (beat_vld_r && adv) begin
      beat_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r <= 1'b0;
    end else begin
      beat_vld_r <= beat_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_data;
    end
  end

  assign beat_vld = beat_vld_r;
  assign beat     = beat_r;

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_vld_r && !adv) |=> (beat_vld_r && $stable(beat_r)))
    else $error("input register lost a blocked beat");

endmodule

// ----- hw/rtl/uamhd_parse_core.sv -----
module uamhd_parse_core import uamhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      beat_vld,
  input  in_beat_t  beat,
  input  logic      adv,
  output logic      res_vld,
  output out_beat_t res
);

  phase_t      phase_r,  phase_nxt;
  logic        short_r,  short_nxt;   // node id with byte namespace and 16-bit id
  logic [1:0]  cnt_r,    cnt_nxt;
  logic [15:0] ns_r,     ns_nxt;
  logic [31:0] id_r,     id_nxt;
  logic [31:0] len_r,    len_nxt;
  logic [30:0] left_r,   left_nxt;

  logic        fire;
  logic        hit;
  logic        err;
  status_t     err_code;
  logic [31:0] byte_shifted;
  logic [31:0] len_word;
  logic [7:0]  b;
  logic        last_in;

  assign fire    = beat_vld && adv;
  assign b       = beat.data_byte;
  assign last_in = beat.buffer_end;

  assign byte_shifted = {24'h000000, b} << {cnt_r, 3'b000};
  assign len_word     = len_r | byte_shifted;

  // Work out the next state and the result for one byte
  always_comb begin
    phase_nxt = phase_r;
    short_nxt = short_r;
    cnt_nxt   = cnt_r;
    ns_nxt    = ns_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    hit       = 1'b0;
    err       = 1'b0;
    err_code  = ST_BAD_NODE;
    res       = '0;

    case (phase_r)
      PH_NODE: begin
        ns_nxt  = '0;
        id_nxt  = '0;
        len_nxt = '0;
        cnt_nxt = '0;
        if (b == NODE_NULL) begin
          short_nxt = 1'b0;
          phase_nxt = PH_BODY;
        end else if (b == NODE_BYTE_NS || b == NODE_WORD_NS) begin
          short_nxt = (b == NODE_BYTE_NS);
          phase_nxt = PH_NS;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_NODE;
        end
      end
      PH_NS: begin
        ns_nxt = ns_r | (cnt_r[0] ? {b, 8'h00} : {8'h00, b});
        if (short_r || cnt_r[0]) begin
          cnt_nxt   = '0;
          phase_nxt = PH_ID;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_ID: begin
        id_nxt = id_r | byte_shifted;
        if (short_r ? (cnt_r == 2'd1) : (cnt_r == 2'd3)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_BODY;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_BODY: begin
        if (b != BODY_BINARY) begin
          err      = 1'b1;
          err_code = ST_BAD_BODY;
        end else begin
          cnt_nxt   = '0;
          len_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt = len_word;
        if (cnt_r == 2'd3) begin
          cnt_nxt = '0;
          if (len_word[31]) begin
            err      = 1'b1;
            err_code = ST_NEG_LEN;
          end else if (len_word == 32'h0) begin
            hit                 = 1'b1;
            res.status          = ST_EMPTY;
            res.last_of_message = 1'b1;
            res.type_id         = id_r;
            res.type_ns         = ns_r;
            phase_nxt           = PH_NODE;
          end else begin
            left_nxt  = len_word[30:0];
            phase_nxt = PH_PAY;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_PAY: begin
        left_nxt            = (left_r == '0) ? '0 : left_r - 31'd1;
        hit                 = 1'b1;
        res.status          = ST_PAYLOAD;
        res.payload_byte    = b;
        res.last_of_message = (left_nxt == '0);
        res.type_id         = id_r;
        res.type_ns         = ns_r;
        res.payload_length  = len_r[30:0];
        if (left_nxt == '0) begin
          phase_nxt = PH_NODE;
        end
      end
      PH_DRAIN: begin
        if (last_in) begin
          phase_nxt = PH_NODE;
        end
      end
      default: begin
        phase_nxt = PH_NODE;
      end
    endcase

    // Errors win; a buffer ending mid-message replaces any payload beat
    if (err) begin
      hit        = 1'b1;
      res        = '0;
      res.status = err_code;
      phase_nxt  = last_in ? PH_NODE : PH_DRAIN;
    end else if (last_in && phase_r != PH_DRAIN && phase_nxt != PH_NODE) begin
      hit        = 1'b1;
      res        = '0;
      res.status = ST_TRUNC;
      phase_nxt  = PH_NODE;
    end
  end

  assign res_vld = beat_vld && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NODE;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end

  // Field accumulators; cleared on each node encoding byte
  always_ff @(posedge clk) begin
    if (fire) begin
      short_r <= short_nxt;
      cnt_r   <= cnt_nxt;
      ns_r    <= ns_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

  a_pay_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> (left_r != '0))
    else $error("payload phase with no bytes left");

  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_vld && phase_r == PH_DRAIN) |-> !res_vld)
    else $error("result produced while draining");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && (res.status == ST_BAD_NODE || res.status == ST_BAD_BODY ||
                 res.status == ST_NEG_LEN || res.status == ST_TRUNC))
    |-> (res.type_id == '0 && res.type_ns == '0 &&
         res.payload_length == '0 && !res.last_of_message))
    else $error("error result carries header fields");

  a_end_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && beat.buffer_end) |=> (phase_r == PH_NODE))
    else $error("buffer end did not return to node encoding");

endmodule

// ----- hw/rtl/uamhd_out_stage.sv -----
module uamhd_out_stage import uamhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      beat_vld,
  input  logic      res_vld,
  input  out_beat_t res,
  input  logic      out_stall,
  output logic      adv,
  output logic      out_valid,
  output out_beat_t out_data
);

  logic      out_valid_r;
  out_beat_t out_data_r;

  // Advance when the result register is empty or being drained
  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_vld && res_vld && !adv) |=> beat_vld)
    else $error("pending result dropped while blocked");

endmodule
